/* hdl/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants for the fenced page bump allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  localparam int unsigned MAX_PAGES_DFLT = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PAGE_W   = 23;  // page size / request size
  localparam int unsigned ALIGN_W  = 5;
  localparam int unsigned FENCE_W  = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 4;   // reported page index
  localparam int unsigned OFS_W    = 22;  // reported byte offset

  localparam logic [PAGE_W-1:0] PAGE_BYTES_RST = PAGE_W'(2097152);

  localparam int unsigned ALU_W = 64;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERSIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   sum;
    logic               carry;  // on subtract: set when a >= b
  } alu_res_t;

endpackage

`default_nettype wire

/* hdl/fpba_in_if.sv */
// ----------------------------------------------------------------------------
// fpba_in_if
// Request channel: one command word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpba_in_if;
  import fpba_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [PAGE_W-1:0]   request_bytes;
  logic [ALIGN_W-1:0]  align_log2;
  logic [FENCE_W-1:0]  fence_value;

  modport source (output valid, operation, request_bytes, align_log2, fence_value,
                  input ready);
  modport sink   (input valid, operation, request_bytes, align_log2, fence_value,
                  output ready);
endinterface

`default_nettype wire

/* hdl/fpba_out_if.sv */
// ----------------------------------------------------------------------------
// fpba_out_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpba_out_if;
  import fpba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [IDX_W-1:0]     page_index;
  logic [OFS_W-1:0]     byte_offset;

  modport source (output valid, status, page_index, byte_offset, input ready);
  modport sink   (input valid, status, page_index, byte_offset, output ready);
endinterface

`default_nettype wire

/* hdl/fpba_alu.sv */
// ----------------------------------------------------------------------------
// fpba_alu
// Shared 64-bit add / subtract-compare unit used by the allocator sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpba_alu (
  input  fpba_pkg::alu_req_t req_i,
  output fpba_pkg::alu_res_t res_o
);
  import fpba_pkg::*;

  logic             sub;
  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   full;

  always_comb begin
    sub   = (req_i.op == ALU_SUB);
    b_eff = sub ? ~req_i.b : req_i.b;
    full  = {1'b0, req_i.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};
    res_o.sum   = full[ALU_W-1:0];
    res_o.carry = full[ALU_W];
  end

endmodule

`default_nettype wire

/* hdl/fenced_page_bump_allocator.sv */
// ----------------------------------------------------------------------------
// fenced_page_bump_allocator
// Bump allocator over a pool of equal-size pages with fence-based recycling.
// ----------------------------------------------------------------------------
// Begin, unused codes, oversize and end with no open page go from decode straight to the
//   result; an allocate aligns, sums and checks fit, and one that needs a page drains
//   completed pending pages and then obtains one; end moves retired pages to pending.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result is loaded into the output register, which waits while that register is full.
// Reset clears control state and sets page_bytes to 2097152; queues read only where written.
`timescale 1ns / 1ps
`default_nettype none

module fenced_page_bump_allocator #(
  parameter int unsigned MAX_PAGES = fpba_pkg::MAX_PAGES_DFLT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fpba_in_if.sink                       req_i,
  fpba_out_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [fpba_pkg::PAGE_W-1:0]   cfg_wdata_i
);
  import fpba_pkg::*;

  localparam int unsigned PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned AW  = 33;  // aligned offset / end offset

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ALIGN, S_SUM, S_FIT, S_DRAIN_RD, S_DRAIN_CMP,
    S_OBTAIN, S_END_RD, S_END_WR, S_RESP
  } state_e;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(MAX_PAGES - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] head,
                                              input logic [CW-1:0] cnt);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(cnt);
    if (s >= (CW+1)'(MAX_PAGES)) s = s - (CW+1)'(MAX_PAGES);
    return s[PW-1:0];
  endfunction

  state_e               state_q;

  // captured command word
  logic [OP_W-1:0]      op_q;
  logic [PAGE_W-1:0]    req_q;
  logic [ALIGN_W-1:0]   lg_q;
  logic [FENCE_W-1:0]   fence_q;

  // allocator state
  logic [PAGE_W-1:0]    page_bytes_q;
  logic                 open_valid_q;
  logic [PW-1:0]        open_page_q;
  logic [PAGE_W-1:0]    fill_q;
  logic [CW-1:0]        frc_q;
  logic [PW-1:0]        pend_head_q;
  logic [CW-1:0]        pend_count_q;
  logic [PW-1:0]        free_head_q;
  logic [CW-1:0]        free_count_q;
  logic [CW-1:0]        pages_made_q;
  logic [FENCE_W-1:0]   done_fence_q;

  // working registers
  logic [AW-1:0]        aligned_q;
  logic [AW-1:0]        end_q;
  logic [CW-1:0]        idx_q;

  // pending result and output register
  status_e              res_status_q;
  logic [IDX_W-1:0]     res_page_q;
  logic [OFS_W-1:0]     res_ofs_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [IDX_W-1:0]     out_page_q;
  logic [OFS_W-1:0]     out_ofs_q;

  // queues
  logic [PW-1:0]        ret_mem       [MAX_PAGES];
  logic [FENCE_W-1:0]   pend_fence_mem[MAX_PAGES];
  logic [PW-1:0]        pend_page_mem [MAX_PAGES];
  logic [PW-1:0]        free_mem      [MAX_PAGES];
  logic [PW-1:0]        ret_rd_q;
  logic [FENCE_W-1:0]   pend_fence_rd_q;
  logic [PW-1:0]        pend_page_rd_q;
  logic [PW-1:0]        free_rd_q;

  alu_req_t             alu_req;
  alu_res_t             alu_res;
  logic [ALU_W-1:0]     align_mask;
  logic                 got_page;
  logic [PW-1:0]        new_page;
  logic                 ret_room;
  logic                 ret_we;
  logic                 pend_we;
  logic                 free_we;
  logic                 in_acc;

  fpba_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign in_acc       = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.page_index  = out_page_q;
  assign rsp_o.byte_offset = out_ofs_q;

  always_comb begin
    align_mask = ~({ALU_W{1'b1}} << lg_q);
    got_page   = (free_count_q != '0) || (pages_made_q < CW'(MAX_PAGES));
    new_page   = (free_count_q != '0) ? free_rd_q : pages_made_q[PW-1:0];
    ret_room   = open_valid_q && (frc_q < CW'(MAX_PAGES));

    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_q)
      S_DECODE: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(page_bytes_q);
        alu_req.b  = ALU_W'(req_q);
      end
      S_ALIGN: begin
        alu_req.a = ALU_W'(fill_q);
        alu_req.b = align_mask;
      end
      S_SUM: begin
        alu_req.a = ALU_W'(aligned_q);
        alu_req.b = ALU_W'(req_q);
      end
      S_FIT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(page_bytes_q);
        alu_req.b  = ALU_W'(end_q);
      end
      S_DRAIN_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = done_fence_q;
        alu_req.b  = pend_fence_rd_q;
      end
      default: ;
    endcase

    ret_we  = ((state_q == S_DECODE) && (op_q == OP_END) && ret_room) ||
              ((state_q == S_OBTAIN) && got_page && ret_room);
    pend_we = (state_q == S_END_WR) && (pend_count_q < CW'(MAX_PAGES));
    free_we = (state_q == S_DRAIN_CMP) && alu_res.carry &&
              (free_count_q < CW'(MAX_PAGES));
  end

  // retired list of the current frame
  always_ff @(posedge clk_i) begin
    if (ret_we) ret_mem[frc_q[PW-1:0]] <= open_page_q;
    ret_rd_q <= ret_mem[idx_q[PW-1:0]];
  end

  // pages waiting on a fence
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_fence_mem[ring_slot(pend_head_q, pend_count_q)] <= fence_q;
      pend_page_mem[ring_slot(pend_head_q, pend_count_q)]  <= ret_rd_q;
    end
    pend_fence_rd_q <= pend_fence_mem[pend_head_q];
    pend_page_rd_q  <= pend_page_mem[pend_head_q];
  end

  // recycled pages
  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[ring_slot(free_head_q, free_count_q)] <= pend_page_rd_q;
    free_rd_q <= free_mem[free_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      req_q        <= '0;
      lg_q         <= '0;
      fence_q      <= '0;
      page_bytes_q <= PAGE_BYTES_RST;
      open_valid_q <= 1'b0;
      open_page_q  <= '0;
      fill_q       <= '0;
      frc_q        <= '0;
      pend_head_q  <= '0;
      pend_count_q <= '0;
      free_head_q  <= '0;
      free_count_q <= '0;
      pages_made_q <= '0;
      done_fence_q <= '0;
      aligned_q    <= '0;
      end_q        <= '0;
      idx_q        <= '0;
      res_status_q <= ST_OK;
      res_page_q   <= '0;
      res_ofs_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_page_q   <= '0;
      out_ofs_q    <= '0;
    end else begin
      if (cfg_we_i) page_bytes_q <= cfg_wdata_i;
      // in S_RESP the output register is handled below
      if (out_valid_q && rsp_o.ready && (state_q != S_RESP)) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q         <= req_i.operation;
            req_q        <= req_i.request_bytes;
            lg_q         <= req_i.align_log2;
            fence_q      <= req_i.fence_value;
            res_status_q <= ST_OK;
            res_page_q   <= '0;
            res_ofs_q    <= '0;
            state_q      <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_q)
            OP_ALLOC: begin
              if (!alu_res.carry) begin
                res_status_q <= ST_OVERSIZE;
                state_q      <= S_RESP;
              end else begin
                state_q <= S_ALIGN;
              end
            end
            OP_BEGIN: begin
              done_fence_q <= fence_q;
              state_q      <= S_RESP;
            end
            OP_END: begin
              if (open_valid_q) begin
                if (ret_room) frc_q <= frc_q + CW'(1);
                open_valid_q <= 1'b0;
                idx_q        <= '0;
                state_q      <= S_END_RD;
              end else begin
                state_q <= S_RESP;
              end
            end
            default: state_q <= S_RESP;
          endcase
        end
        S_ALIGN: begin
          aligned_q <= alu_res.sum[AW-1:0] & ~align_mask[AW-1:0];
          state_q   <= S_SUM;
        end
        S_SUM: begin
          end_q   <= alu_res.sum[AW-1:0];
          state_q <= S_FIT;
        end
        S_FIT: begin
          if (open_valid_q && alu_res.carry) begin
            fill_q     <= end_q[PAGE_W-1:0];
            res_page_q <= IDX_W'(open_page_q);
            res_ofs_q  <= aligned_q[OFS_W-1:0];
            state_q    <= S_RESP;
          end else begin
            state_q <= S_DRAIN_RD;
          end
        end
        S_DRAIN_RD: begin
          // head entry is being read this cycle
          state_q <= (pend_count_q != '0) ? S_DRAIN_CMP : S_OBTAIN;
        end
        S_DRAIN_CMP: begin
          if (alu_res.carry) begin
            if (free_count_q < CW'(MAX_PAGES)) free_count_q <= free_count_q + CW'(1);
            pend_head_q  <= wrap_inc(pend_head_q);
            pend_count_q <= pend_count_q - CW'(1);
            state_q      <= S_DRAIN_RD;
          end else begin
            state_q <= S_OBTAIN;
          end
        end
        S_OBTAIN: begin
          if (got_page) begin
            if (free_count_q != '0) begin
              free_head_q  <= wrap_inc(free_head_q);
              free_count_q <= free_count_q - CW'(1);
            end else begin
              pages_made_q <= pages_made_q + CW'(1);
            end
            if (ret_room) frc_q <= frc_q + CW'(1);
            open_page_q  <= new_page;
            open_valid_q <= 1'b1;
            fill_q       <= req_q;
            res_page_q   <= IDX_W'(new_page);
          end else begin
            res_status_q <= ST_EXHAUSTED;
          end
          state_q <= S_RESP;
        end
        S_END_RD: begin
          if (idx_q == frc_q) begin
            frc_q   <= '0;
            state_q <= S_RESP;
          end else begin
            state_q <= S_END_WR;
          end
        end
        S_END_WR: begin
          if (pend_we) pend_count_q <= pend_count_q + CW'(1);
          idx_q   <= idx_q + CW'(1);
          state_q <= S_END_RD;
        end
        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_page_q   <= res_page_q;
            out_ofs_q    <= res_ofs_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---- assertions ----
  a_pool_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pages_made_q <= CW'(MAX_PAGES)) && (free_count_q <= pages_made_q))
    else $error("page pool counters out of range");

  a_open_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(open_valid_q) |-> ($past(state_q) == S_DECODE) && ($past(op_q) == OP_END))
    else $error("open page dropped outside an end word");

  a_err_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |-> (out_page_q == '0) && (out_ofs_q == '0))
    else $error("error result carries a page or offset");

  a_retired_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && (frc_q != '0)) |-> open_valid_q)
    else $error("retired pages without an open page");

endmodule

`default_nettype wire
